### hdl/glyph_text_pixel_writer_unit_defines.svh
// Assertion macros shared by the glyph writer RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef GLYPH_TEXT_PIXEL_WRITER_UNIT_DEFINES_SVH
`define GLYPH_TEXT_PIXEL_WRITER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define GTPW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gtpw assertion failed");
`define GTPW_NEVER(lbl, cond) \
    `GTPW_ASSERT(lbl, !(cond))
`else
`define GTPW_ASSERT(lbl, prop)
`define GTPW_NEVER(lbl, cond)
`endif
`endif

### hdl/gtpw_pkg.sv
// Types and constants shared by the glyph text pixel writer.
// No dependencies.
package gtpw_pkg;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_ROW   = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        REG_FG_COLOUR    = 3'd0,
        REG_BG_COLOUR    = 3'd1,
        REG_GLYPH_WIDTH  = 3'd2,
        REG_GLYPH_HEIGHT = 3'd3,
        REG_FRAME_PITCH  = 3'd4,
        REG_FRAME_BASE   = 3'd5
    } reg_idx_t;

    localparam logic [31:0] TRANSPARENT_COLOUR = 32'hFF00_0000;
    localparam logic [31:0] FG_RESET           = 32'h00FF_FFFF;
    localparam logic [31:0] BG_RESET           = 32'hFF00_0000;
    localparam logic [5:0]  WIDTH_RESET        = 6'd8;
    localparam logic [5:0]  HEIGHT_RESET       = 6'd16;
    localparam logic [15:0] PITCH_RESET        = 16'd1024;
    localparam logic [31:0] BASE_RESET         = 32'd0;

    localparam int RESULT_CAP  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Settings seen by the front and back ends; sizes are already saturated.
    typedef struct packed
    {
        logic [31:0] fg_colour;
        logic [31:0] bg_colour;
        logic [5:0]  width;
        logic [5:0]  height;
        logic [15:0] pitch;
        logic [31:0] base;
    } cfg_t;

    // One glyph row ready for the pixel serialiser.
    typedef struct packed
    {
        logic [31:0] addr;
        logic [31:0] bits;
    } job_t;

endpackage

### hdl/glyph_text_pixel_writer_unit.sv
// Top level of the glyph text pixel writer: register file and the
// front end, row queue and pixel back end. Depends on gtpw_pkg.
//
//  Port group   Dir  Moves
//  s_*          in   start or glyph-row requests
//  m_*          out  framebuffer pixel writes
//  APB          in   settings registers at 4*index
//
// A glyph row yields as many pixels as the saturated glyph width (8 at reset),
// one a cycle from the back end's single output register while m_tready does
// not stall it. A start request yields nothing. The first pixel of a row
// leaves through a two-stage address pipeline, a four-entry queue and the
// output register. The front keeps taking requests while the back end is
// stalled, until the rows in the queue and pipeline together reach the queue
// depth. Reset clears all control state; no clearing pass is needed.
module glyph_text_pixel_writer_unit #(
    parameter int MAX_GLYPH_WIDTH  = 32,
    parameter int MAX_GLYPH_HEIGHT = 32,
    parameter int COORD_WIDTH      = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] origin_x, [31:16] origin_y, [47:32] wrap_width, [79:48] row_bits
    input  logic [79:0] s_tdata,
    // [0] command
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] pixel_address, [63:32] colour
    output logic [63:0] m_tdata,
    // [0] write_enable
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int WLIM = (MAX_GLYPH_WIDTH < gtpw_pkg::RESULT_CAP) ?
                          MAX_GLYPH_WIDTH : gtpw_pkg::RESULT_CAP;
    localparam int HLIM = (MAX_GLYPH_HEIGHT < gtpw_pkg::RESULT_CAP) ?
                          MAX_GLYPH_HEIGHT : gtpw_pkg::RESULT_CAP;

    logic [31:0] fg_colour_reg;
    logic [31:0] bg_colour_reg;
    logic [5:0]  glyph_width_reg;
    logic [5:0]  glyph_height_reg;
    logic [15:0] frame_pitch_reg;
    logic [31:0] frame_base_reg;

    logic                        cfg_write;
    gtpw_pkg::cfg_t              cfg;
    logic                        push, pop, head_valid;
    gtpw_pkg::job_t              push_job, head_job;
    logic [gtpw_pkg::QCNT_W-1:0] q_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_colour_reg    <= gtpw_pkg::FG_RESET;
            bg_colour_reg    <= gtpw_pkg::BG_RESET;
            glyph_width_reg  <= gtpw_pkg::WIDTH_RESET;
            glyph_height_reg <= gtpw_pkg::HEIGHT_RESET;
            frame_pitch_reg  <= gtpw_pkg::PITCH_RESET;
            frame_base_reg   <= gtpw_pkg::BASE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                gtpw_pkg::REG_FG_COLOUR:    fg_colour_reg    <= pwdata;
                gtpw_pkg::REG_BG_COLOUR:    bg_colour_reg    <= pwdata;
                gtpw_pkg::REG_GLYPH_WIDTH:  glyph_width_reg  <= pwdata[5:0];
                gtpw_pkg::REG_GLYPH_HEIGHT: glyph_height_reg <= pwdata[5:0];
                gtpw_pkg::REG_FRAME_PITCH:  frame_pitch_reg  <= pwdata[15:0];
                gtpw_pkg::REG_FRAME_BASE:   frame_base_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            gtpw_pkg::REG_FG_COLOUR:    prdata = fg_colour_reg;
            gtpw_pkg::REG_BG_COLOUR:    prdata = bg_colour_reg;
            gtpw_pkg::REG_GLYPH_WIDTH:  prdata = 32'(glyph_width_reg);
            gtpw_pkg::REG_GLYPH_HEIGHT: prdata = 32'(glyph_height_reg);
            gtpw_pkg::REG_FRAME_PITCH:  prdata = 32'(frame_pitch_reg);
            gtpw_pkg::REG_FRAME_BASE:   prdata = frame_base_reg;
            default:                    prdata = 32'd0;
        endcase
    end

    // A size of zero acts as one; larger sizes clip to the supported maximum.
    always_comb
    begin
        cfg.fg_colour = fg_colour_reg;
        cfg.bg_colour = bg_colour_reg;
        cfg.pitch     = frame_pitch_reg;
        cfg.base      = frame_base_reg;
        if (glyph_width_reg == 6'd0)
            cfg.width = 6'd1;
        else if (glyph_width_reg > 6'(WLIM))
            cfg.width = 6'(WLIM);
        else
            cfg.width = glyph_width_reg;
        if (glyph_height_reg == 6'd0)
            cfg.height = 6'd1;
        else if (glyph_height_reg > 6'(HLIM))
            cfg.height = 6'(HLIM);
        else
            cfg.height = glyph_height_reg;
    end

    gtpw_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .q_count  (q_count),
        .push     (push),
        .job      (push_job)
    );

    gtpw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .count      (q_count)
    );

    gtpw_back #(
        .MAX_COLS (WLIM)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

### hdl/gtpw_front.sv
// Front end: accepts requests, keeps the text cursor and works out the
// start address of each glyph row. Depends on gtpw_pkg.
`include "glyph_text_pixel_writer_unit_defines.svh"
module gtpw_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic                      s_tuser,
    input  logic [79:0]               s_tdata,
    input  gtpw_pkg::cfg_t            cfg,
    input  logic [gtpw_pkg::QCNT_W-1:0] q_count,
    output logic                      push,
    output gtpw_pkg::job_t            job
);
    localparam int CW = COORD_WIDTH;
    localparam int PW = COORD_WIDTH + 16;

    logic [CW-1:0] cursor_x_reg, cursor_x_next;
    logic [CW-1:0] cursor_y_reg, cursor_y_next;
    logic [CW-1:0] return_x_reg, return_x_next;
    logic [CW-1:0] wrap_limit_reg, wrap_limit_next;
    logic [4:0]    row_count_reg, row_count_next;

    logic          s1_valid_reg, s2_valid_reg;
    logic [CW-1:0] s1_line_reg, s1_cx_reg, s2_cx_reg;
    logic [31:0]   s1_bits_reg, s2_bits_reg;
    logic [PW-1:0] s2_prod_reg;

    logic          accept, row_accept;
    logic [3:0]    occupancy;
    logic [CW-1:0] line, cx_adv;
    logic          wrap_hit;
    logic [63:0]   prod_ext;

    // Credit check: rows already in the address pipeline are counted
    // against the queue so that a push never finds it full.
    assign occupancy = 4'(q_count) + 4'(s1_valid_reg) + 4'(s2_valid_reg);
    assign s_tready  = occupancy < 4'(gtpw_pkg::QUEUE_DEPTH);
    assign accept     = s_tvalid && s_tready;
    assign row_accept = accept && (s_tuser == gtpw_pkg::CMD_ROW);

    assign line     = cursor_y_reg + CW'(row_count_reg);
    assign cx_adv   = cursor_x_reg + CW'(cfg.width) + CW'(1);
    assign wrap_hit = ((CW+1)'(cx_adv) + (CW+1)'(cfg.width)) >= (CW+1)'(wrap_limit_reg);

    always_comb
    begin
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        return_x_next   = return_x_reg;
        wrap_limit_next = wrap_limit_reg;
        row_count_next  = row_count_reg;
        if (accept && (s_tuser == gtpw_pkg::CMD_START))
        begin
            cursor_x_next   = CW'(s_tdata[15:0]);
            return_x_next   = CW'(s_tdata[15:0]);
            cursor_y_next   = CW'(s_tdata[31:16]);
            wrap_limit_next = CW'(s_tdata[47:32]);
            row_count_next  = 5'd0;
        end
        else if (row_accept)
        begin
            if ((6'(row_count_reg) + 6'd1) >= cfg.height)
            begin
                row_count_next = 5'd0;
                if (wrap_hit)
                begin
                    cursor_y_next = cursor_y_reg + CW'(cfg.height);
                    cursor_x_next = return_x_reg;
                end
                else
                begin
                    cursor_x_next = cx_adv;
                end
            end
            else
            begin
                row_count_next = row_count_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            return_x_reg   <= '0;
            wrap_limit_reg <= '0;
            row_count_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            return_x_reg   <= return_x_next;
            wrap_limit_reg <= wrap_limit_next;
            row_count_reg  <= row_count_next;
            s1_valid_reg   <= row_accept;
            s2_valid_reg   <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_line_reg <= line;
        s1_cx_reg   <= cursor_x_reg;
        s1_bits_reg <= s_tdata[79:48];
        s2_prod_reg <= PW'(s1_line_reg) * PW'(cfg.pitch);
        s2_cx_reg   <= s1_cx_reg;
        s2_bits_reg <= s1_bits_reg;
    end

    assign prod_ext = 64'(s2_prod_reg);
    assign push     = s2_valid_reg;
    assign job.addr = cfg.base + prod_ext[31:0] + 32'(s2_cx_reg);
    assign job.bits = s2_bits_reg;

    `GTPW_ASSERT(a_row_enters_pipe, row_accept |=> s1_valid_reg)

endmodule

### hdl/gtpw_queue.sv
// Short queue of glyph rows between the front and back ends.
// Depends on gtpw_pkg.
`include "glyph_text_pixel_writer_unit_defines.svh"
module gtpw_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  gtpw_pkg::job_t              push_job,
    input  logic                        pop,
    output logic                        head_valid,
    output gtpw_pkg::job_t              head_job,
    output logic [gtpw_pkg::QCNT_W-1:0] count
);
    gtpw_pkg::job_t                entry_reg [gtpw_pkg::QUEUE_DEPTH];
    logic [gtpw_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [gtpw_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [gtpw_pkg::QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + gtpw_pkg::QCNT_W'(push) - gtpw_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    `GTPW_NEVER(a_no_overflow, push && (count_reg == gtpw_pkg::QCNT_W'(gtpw_pkg::QUEUE_DEPTH)))
    `GTPW_NEVER(a_no_underflow, pop && (count_reg == '0))

endmodule

### hdl/gtpw_back.sv
// Back end: walks the pixels of the row at the queue head into the output
// register, one a cycle while m_tready does not stall it. Depends on gtpw_pkg.
`include "glyph_text_pixel_writer_unit_defines.svh"
module gtpw_back #(
    parameter int MAX_COLS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  gtpw_pkg::cfg_t cfg,
    input  logic           head_valid,
    input  gtpw_pkg::job_t head_job,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,
    output logic           m_tuser,
    output logic           m_tlast
);
    localparam int CB = $clog2(MAX_COLS);

    logic [CB-1:0] col_reg;
    logic          out_valid_reg;
    logic [31:0]   out_addr_reg, out_colour_reg;
    logic          out_we_reg, out_last_reg;

    logic          load, last;
    logic [4:0]    bit_idx;
    logic [31:0]   colour;

    assign load    = head_valid && (!out_valid_reg || m_tready);
    assign last    = ((CB+1)'(col_reg) + (CB+1)'(1)) == (CB+1)'(cfg.width);
    assign pop     = load && last;
    assign bit_idx = 5'd31 - 5'(col_reg);
    assign colour  = head_job.bits[bit_idx] ? cfg.fg_colour : cfg.bg_colour;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                col_reg       <= last ? '0 : col_reg + 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_addr_reg   <= head_job.addr + 32'(col_reg);
            out_colour_reg <= colour;
            out_we_reg     <= colour != gtpw_pkg::TRANSPARENT_COLOUR;
            out_last_reg   <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_colour_reg, out_addr_reg};
    assign m_tuser  = out_we_reg;
    assign m_tlast  = out_last_reg;

    `GTPW_ASSERT(a_pop_on_last, pop |=> (out_valid_reg && out_last_reg))

endmodule

### test/glyph_text_pixel_writer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for glyph_text_pixel_writer_unit: drives start and glyph-row
// requests and APB settings writes, and predicts every framebuffer pixel write.
// Depends on gtpw_pkg and the glyph_text_pixel_writer_unit RTL only.
module glyph_text_pixel_writer_unit_tb;

    typedef struct packed
    {
        logic [31:0] addr;
        logic [31:0] colour;
        logic        we;
        logic        last;
    } pixel_write_t;

    typedef struct packed
    {
        logic               is_cfg;
        gtpw_pkg::reg_idx_t reg_sel;
        logic [31:0]        value;
        gtpw_pkg::cmd_t     cmd;
        logic [15:0]        ox;
        logic [15:0]        oy;
        logic [15:0]        ww;
        logic [31:0]        bits;
        logic               has_first;
        pixel_write_t       first;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the settings registers.
    logic [31:0] ink_colour;
    logic [31:0] paper_colour;
    logic [5:0]  glyph_w_reg;
    logic [5:0]  glyph_h_reg;
    logic [15:0] line_pitch;
    logic [31:0] fb_base;

    // Predictor copy of the text cursor.
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [15:0] margin_x;
    logic [15:0] wrap_col;
    logic [4:0]  rows_drawn;

    pixel_write_t pending_writes[$];
    script_row_t  directed_script[$];

    int mismatches;
    int pixels_checked;
    int starts_sent;
    int rows_sent;
    int cfg_writes;
    int rx_stall_left;
    bit s_quiet;
    bit m_quiet;

    glyph_text_pixel_writer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    function automatic int clamp_size(input logic [5:0] v);
        if (v == 6'd0)
            return 1;
        if (v > gtpw_pkg::RESULT_CAP)
            return gtpw_pkg::RESULT_CAP;
        return int'(v);
    endfunction

    // Updates the cursor for one request and queues the pixel writes it should cause.
    function automatic int render_request(input gtpw_pkg::cmd_t cmd, input logic [15:0] ox,
                                          input logic [15:0] oy, input logic [15:0] ww,
                                          input logic [31:0] bits);
        int           w;
        int           h;
        int           j;
        logic [15:0]  line;
        logic [31:0]  row_addr;
        pixel_write_t px;
        if (cmd == gtpw_pkg::CMD_START)
        begin
            pen_x      = ox;
            margin_x   = ox;
            pen_y      = oy;
            wrap_col   = ww;
            rows_drawn = 5'd0;
            return 0;
        end
        w        = clamp_size(glyph_w_reg);
        h        = clamp_size(glyph_h_reg);
        line     = pen_y + rows_drawn;
        row_addr = fb_base + 32'(line) * 32'(line_pitch) + 32'(pen_x);
        for (j = 0; j < w; j++)
        begin
            px.addr   = row_addr + j;
            px.colour = bits[31 - j] ? ink_colour : paper_colour;
            px.we     = (px.colour != gtpw_pkg::TRANSPARENT_COLOUR);
            px.last   = (j == w - 1);
            pending_writes.push_back(px);
        end
        if (32'(rows_drawn) + 1 >= h)
        begin
            rows_drawn = 5'd0;
            pen_x      = 16'(32'(pen_x) + w + 1);
            // The wrap test adds the width to the 16-bit wrapped column without wrapping again.
            if (32'(pen_x) + w >= 32'(wrap_col))
            begin
                pen_y = 16'(32'(pen_y) + h);
                pen_x = margin_x;
            end
        end
        else
            rows_drawn = rows_drawn + 5'd1;
        return w;
    endfunction

    task automatic send_request(input gtpw_pkg::cmd_t cmd, input logic [15:0] ox,
                                input logic [15:0] oy,
                                input logic [15:0] ww, input logic [31:0] bits,
                                output int n_px);
        int gap;
        gap = s_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {bits, ww, oy, ox};
        do
            @(posedge clk);
        while (!s_tready);
        n_px = render_request(cmd, ox, oy, ww, bits);
        if (cmd == gtpw_pkg::CMD_START)
            starts_sent++;
        else
            rows_sent++;
    endtask

    // Lets the block run dry; a trailing start request yields nothing to wait for.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic apb_write(input gtpw_pkg::reg_idx_t idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            gtpw_pkg::REG_FG_COLOUR:    ink_colour   = v;
            gtpw_pkg::REG_BG_COLOUR:    paper_colour = v;
            gtpw_pkg::REG_GLYPH_WIDTH:  glyph_w_reg  = v[5:0];
            gtpw_pkg::REG_GLYPH_HEIGHT: glyph_h_reg  = v[5:0];
            gtpw_pkg::REG_FRAME_PITCH:  line_pitch   = v[15:0];
            gtpw_pkg::REG_FRAME_BASE:   fb_base      = v;
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic add_cfg(input gtpw_pkg::reg_idx_t idx, input logic [31:0] v);
        script_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = idx;
        r.value   = v;
        directed_script.push_back(r);
    endtask

    task automatic add_req(input gtpw_pkg::cmd_t cmd, input logic [15:0] ox,
                           input logic [15:0] oy,
                           input logic [15:0] ww, input logic [31:0] bits, input bit chk,
                           input logic [31:0] addr, input logic [31:0] colour,
                           input logic we, input logic last);
        script_row_t r;
        r              = '0;
        r.cmd          = cmd;
        r.ox           = ox;
        r.oy           = oy;
        r.ww           = ww;
        r.bits         = bits;
        r.has_first    = chk;
        r.first.addr   = addr;
        r.first.colour = colour;
        r.first.we     = we;
        r.first.last   = last;
        directed_script.push_back(r);
    endtask

    function automatic logic [5:0] pick_size(input bit short_range);
        case ($urandom_range(0, 9))
            0: return 6'd0;
            1: return 6'd63;
            2: return 6'd32;
            3: return 6'($urandom_range(33, 62));
            default: return short_range ? 6'($urandom_range(1, 4)) : 6'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [31:0] pick_colour();
        case ($urandom_range(0, 4))
            0: return gtpw_pkg::TRANSPARENT_COLOUR;
            1: return 32'h0000_0000;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF - 16'($urandom_range(0, 63));
            default: return 16'($urandom);
        endcase
    endfunction

    // Pixel sink: random back-pressure, and every accepted write checked in order.
    always @(posedge clk)
    begin : pixel_sink
        pixel_write_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_writes.size() == 0)
                report_mismatch("pixel write with nothing pending, address",
                                m_tdata[31:0], 32'h0);
            else
            begin
                want = pending_writes.pop_front();
                pixels_checked++;
                if (m_tdata[31:0] !== want.addr)
                    report_mismatch("pixel address", m_tdata[31:0], want.addr);
                if (m_tdata[63:32] !== want.colour)
                    report_mismatch("pixel colour", m_tdata[63:32], want.colour);
                if (m_tuser !== want.we)
                    report_mismatch("write enable", 32'(m_tuser), 32'(want.we));
                if (m_tlast !== want.last)
                    report_mismatch("last pixel flag", 32'(m_tlast), 32'(want.last));
            end
            rx_stall_left = m_quiet ? 0 : $urandom_range(0, 14);
            m_tready <= (rx_stall_left == 0);
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            if (rx_stall_left == 0)
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        script_row_t    r;
        int             n_px;
        int             phase;
        int             sent;
        int             k;
        gtpw_pkg::cmd_t cmd;
        logic [15:0]    ox;
        logic [15:0]    oy;
        logic [15:0]    ww;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= gtpw_pkg::CMD_START;
        s_tdata  <= '0;
        m_tready <= 1'b1;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        ink_colour     = gtpw_pkg::FG_RESET;
        paper_colour   = gtpw_pkg::BG_RESET;
        glyph_w_reg    = gtpw_pkg::WIDTH_RESET;
        glyph_h_reg    = gtpw_pkg::HEIGHT_RESET;
        line_pitch     = gtpw_pkg::PITCH_RESET;
        fb_base        = gtpw_pkg::BASE_RESET;
        pen_x          = '0;
        pen_y          = '0;
        margin_x       = '0;
        wrap_col       = '0;
        rows_drawn     = '0;
        mismatches     = 0;
        pixels_checked = 0;
        starts_sent    = 0;
        rows_sent      = 0;
        cfg_writes     = 0;
        rx_stall_left  = 0;
        s_quiet        = 1'b0;
        m_quiet        = 1'b0;

        // Rows straight after reset use the reset settings and a cursor at the origin.
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF,
                1, 32'h0000_0000, gtpw_pkg::FG_RESET, 1'b1, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'h0000_0000,
                1, 32'h0000_0400, gtpw_pkg::BG_RESET, 1'b0, 1'b0);
        // Zero sizes act as one: each row is a whole one-pixel glyph.
        add_cfg(gtpw_pkg::REG_GLYPH_WIDTH, 32'd0);
        add_cfg(gtpw_pkg::REG_GLYPH_HEIGHT, 32'd0);
        add_req(gtpw_pkg::CMD_START, 16'hFFFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'h8000_0000,
                1, 32'h0400_FBFF, gtpw_pkg::FG_RESET, 1'b1, 1'b1);
        add_req(gtpw_pkg::CMD_ROW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF,
                1, 32'h0000_FFFF, gtpw_pkg::BG_RESET, 1'b0, 1'b1);
        // Oversized settings saturate; a transparent foreground is skipped.
        add_cfg(gtpw_pkg::REG_FG_COLOUR, gtpw_pkg::TRANSPARENT_COLOUR);
        add_cfg(gtpw_pkg::REG_BG_COLOUR, 32'h0000_0000);
        add_cfg(gtpw_pkg::REG_GLYPH_WIDTH, 32'd63);
        add_cfg(gtpw_pkg::REG_GLYPH_HEIGHT, 32'd63);
        add_cfg(gtpw_pkg::REG_FRAME_PITCH, 32'h0000_FFFF);
        add_cfg(gtpw_pkg::REG_FRAME_BASE, 32'hFFFF_FFFF);
        add_req(gtpw_pkg::CMD_START, 16'h0000, 16'hFFFF, 16'hFFFF, 32'h0,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'hA5A5_A5A5,
                1, 32'hFFFE_0000, gtpw_pkg::TRANSPARENT_COLOUR, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'h5A5A_5A5A,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        // Height dropped below the rows already drawn ends the glyph at once.
        add_cfg(gtpw_pkg::REG_GLYPH_HEIGHT, 32'd2);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'h0F0F_0F0F,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        // With a zero pitch every line lands on the same addresses.
        add_cfg(gtpw_pkg::REG_FRAME_PITCH, 32'd0);
        add_cfg(gtpw_pkg::REG_FRAME_BASE, 32'd0);
        add_cfg(gtpw_pkg::REG_FG_COLOUR, 32'h1234_5678);
        add_cfg(gtpw_pkg::REG_BG_COLOUR, 32'hFFFF_FFFF);
        add_cfg(gtpw_pkg::REG_GLYPH_WIDTH, 32'd32);
        add_cfg(gtpw_pkg::REG_GLYPH_HEIGHT, 32'd32);
        add_req(gtpw_pkg::CMD_START, 16'd10, 16'd20, 16'd30, 32'h0,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'hFFFF_0000,
                1, 32'h0000_000A, 32'h1234_5678, 1'b1, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'h0000_FFFF,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        // The next glyph would run past the top of the 16-bit column range, so the cursor wraps to a new line.
        add_cfg(gtpw_pkg::REG_GLYPH_HEIGHT, 32'd1);
        add_cfg(gtpw_pkg::REG_GLYPH_WIDTH, 32'd8);
        add_cfg(gtpw_pkg::REG_FRAME_PITCH, 32'd640);
        add_req(gtpw_pkg::CMD_START, 16'hFFF0, 16'd5, 16'hFFFF, 32'hFFFF_FFFF,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h1234, 16'h5678, 16'h9ABC, 32'hC300_0000,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'h3C00_0000,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'hAA00_0000,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_START, 16'd100, 16'd7, 16'd118, 32'h0,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'h5500_0000,
                0, 32'h0, 32'h0, 1'b0, 1'b0);
        add_req(gtpw_pkg::CMD_ROW, 16'h0, 16'h0, 16'h0, 32'hFF00_0000,
                0, 32'h0, 32'h0, 1'b0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_script[i])
        begin
            r = directed_script[i];
            if (r.is_cfg)
            begin
                settle();
                apb_write(r.reg_sel, r.value);
            end
            else
            begin
                send_request(r.cmd, r.ox, r.oy, r.ww, r.bits, n_px);
                // Hand-worked first pixel replaces the predicted one for this row.
                if (r.has_first)
                    pending_writes[pending_writes.size() - n_px] = r.first;
            end
        end

        for (phase = 0; phase < 8; phase++)
        begin
            settle();
            apb_write(gtpw_pkg::REG_FG_COLOUR, pick_colour());
            apb_write(gtpw_pkg::REG_BG_COLOUR, pick_colour());
            apb_write(gtpw_pkg::REG_GLYPH_WIDTH, 32'(pick_size(1'b0)));
            apb_write(gtpw_pkg::REG_GLYPH_HEIGHT, 32'(pick_size(1'b1)));
            case ($urandom_range(0, 4))
                0: apb_write(gtpw_pkg::REG_FRAME_PITCH, 32'd0);
                1: apb_write(gtpw_pkg::REG_FRAME_PITCH, 32'd1);
                2: apb_write(gtpw_pkg::REG_FRAME_PITCH, 32'h0000_FFFF);
                default: apb_write(gtpw_pkg::REG_FRAME_PITCH,
                                   32'($urandom_range(1, 65535)));
            endcase
            case ($urandom_range(0, 3))
                0: apb_write(gtpw_pkg::REG_FRAME_BASE, 32'h0);
                1: apb_write(gtpw_pkg::REG_FRAME_BASE, 32'hFFFF_FFFF);
                default: apb_write(gtpw_pkg::REG_FRAME_BASE, $urandom);
            endcase
            s_quiet = ($urandom_range(0, 3) == 0);
            m_quiet = ($urandom_range(0, 3) == 0);

            sent = 0;
            while (sent < 41)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // Stray request with every field random, start or row alike.
                    cmd = $urandom_range(0, 1) ? gtpw_pkg::CMD_ROW : gtpw_pkg::CMD_START;
                    send_request(cmd, 16'($urandom), 16'($urandom), 16'($urandom),
                                 $urandom, n_px);
                    sent++;
                end
                else
                begin
                    ox = pick_coord();
                    oy = pick_coord();
                    case ($urandom_range(0, 5))
                        0: ww = 16'h0000;
                        1: ww = 16'hFFFF;
                        2: ww = 16'($urandom);
                        default: ww = ox + 16'($urandom_range(0, 100));
                    endcase
                    send_request(gtpw_pkg::CMD_START, ox, oy, ww, $urandom, n_px);
                    sent++;
                    k = $urandom_range(1, 10);
                    repeat (k)
                    begin
                        send_request(gtpw_pkg::CMD_ROW, 16'($urandom), 16'($urandom),
                                     16'($urandom), $urandom, n_px);
                        sent++;
                    end
                end
            end
        end

        settle();
        if (pending_writes.size() != 0)
            report_mismatch("pixel writes never seen", pending_writes.size(), 32'h0);
        $display("Sent %0d start and %0d glyph-row requests over %0d register writes.",
                 starts_sent, rows_sent, cfg_writes);
        $display("Checked %0d pixel writes against the predicted framebuffer traffic.",
                 pixels_checked);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/gtpw_pkg.sv
hdl/gtpw_front.sv
hdl/gtpw_queue.sv
hdl/gtpw_back.sv
hdl/glyph_text_pixel_writer_unit.sv
test/glyph_text_pixel_writer_unit_tb.sv
